[rtl/bbp_pkg.sv]
package bbp_pkg;

  localparam int MAX_INDEX_BITS = 12;
  localparam int CfgW = 4;
  localparam int CntW = 2;
  localparam int AddrW = 32;
  localparam int TotalW = 32;

  localparam logic [CfgW-1:0] INDEX_BITS_RESET = 4'd12;

  localparam logic [CntW-1:0] CNT_STRONG_NT = 2'd0;
  localparam logic [CntW-1:0] CNT_WEAK_NT   = 2'd1;
  localparam logic [CntW-1:0] CNT_WEAK_T    = 2'd2;
  localparam logic [CntW-1:0] CNT_STRONG_T  = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0] branch_address;
    logic             actual_taken;
  } bbp_in_t;

  typedef struct packed {
    logic              predict_taken;
    logic              mispredicted;
    logic [TotalW-1:0] mispredict_total;
  } bbp_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } bbp_state_e;

  function automatic logic [CntW-1:0] next_counter(logic [CntW-1:0] cur, logic taken);
    logic [CntW-1:0] res;
    if (taken) begin
      res = (cur == CNT_STRONG_NT) ? CNT_WEAK_NT : CNT_STRONG_T;
    end else begin
      res = (cur == CNT_STRONG_T) ? CNT_WEAK_T : CNT_STRONG_NT;
    end
    return res;
  endfunction

endpackage

[rtl/bimodal_branch_predictor.sv]
// Bimodal branch predictor with 2-bit hysteresis counters. Each input transaction
// (branch address, resolved outcome) reads one counter from a synchronous
// table of 2**MaxIndexBits entries, selected by the low index_bits address bits
// (clamped to MaxIndexBits, zero selects entry 0), and returns the prediction
// made before the update, a mispredict flag and a saturating mispredict total.
// A transaction reads the counter memory, then updates the counter and writes it
// back through the memory's single write port; the next input is taken while a
// result still waits on the output register. After reset the block sweeps the
// table to strongly taken, one entry per cycle, all 2**MaxIndexBits entries (4096
// by default) with in_ready_o low; configuration writes are taken at any time.
module bimodal_branch_predictor #(
  parameter int MaxIndexBits = bbp_pkg::MAX_INDEX_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bbp_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bbp_pkg::bbp_in_t            in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bbp_pkg::bbp_out_t           out_o
);

  localparam int Depth = 2 ** MaxIndexBits;
  localparam int IdxW = MaxIndexBits;
  localparam int BitsMax = (MaxIndexBits > 15) ? MaxIndexBits : 15;
  localparam int BitsW = $clog2(BitsMax + 1);

  bbp_pkg::bbp_state_e state_q, state_d;

  logic [bbp_pkg::CfgW-1:0]   index_bits_q;
  logic [IdxW-1:0]            clr_q, clr_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic                       taken_q, taken_d;
  logic [bbp_pkg::TotalW-1:0] miss_q, miss_d;
  logic                       out_valid_q, out_valid_d;
  bbp_pkg::bbp_out_t          out_q, out_d;

  logic [BitsW-1:0]           eff_bits;
  logic [IdxW-1:0]            idx_mask;
  logic [IdxW-1:0]            in_idx;

  logic                       ram_we;
  logic [IdxW-1:0]            ram_waddr;
  logic [bbp_pkg::CntW-1:0]   ram_wdata;
  logic                       ram_re;
  logic [bbp_pkg::CntW-1:0]   ram_rdata;

  logic                       pred;
  logic                       miss;
  logic [bbp_pkg::TotalW-1:0] miss_next;

  assign eff_bits = (32'(index_bits_q) > 32'(MaxIndexBits)) ? BitsW'(MaxIndexBits)
                                                           : BitsW'(index_bits_q);
  assign idx_mask = ~({IdxW{1'b1}} << eff_bits);
  assign in_idx   = in_i.branch_address[IdxW-1:0] & idx_mask;

  assign pred = (ram_rdata == bbp_pkg::CNT_STRONG_T) || (ram_rdata == bbp_pkg::CNT_WEAK_T);
  assign miss = pred != taken_q;
  assign miss_next = (miss && (miss_q != '1)) ? miss_q + 1'b1 : miss_q;

  bbp_ram #(
    .Width (bbp_pkg::CntW),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    taken_d     = taken_q;
    miss_d      = miss_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = bbp_pkg::next_counter(ram_rdata, taken_q);
    ram_re      = 1'b0;
    case (state_q)
      bbp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = bbp_pkg::CNT_STRONG_T;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = bbp_pkg::ST_IDLE;
        end
      end
      bbp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ram_re  = 1'b1;
          idx_d   = in_idx;
          taken_d = in_i.actual_taken;
          state_d = bbp_pkg::ST_UPDATE;
        end
      end
      bbp_pkg::ST_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          ram_we                 = 1'b1;
          miss_d                 = miss_next;
          out_valid_d            = 1'b1;
          out_d.predict_taken    = pred;
          out_d.mispredicted     = miss;
          out_d.mispredict_total = miss_next;
          state_d                = bbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bbp_pkg::ST_CLEAR;
      clr_q        <= '0;
      index_bits_q <= bbp_pkg::INDEX_BITS_RESET;
      miss_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      miss_q      <= miss_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        index_bits_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    taken_q <= taken_d;
    out_q   <= out_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[rtl/bbp_ram.sv]
module bbp_ram #(
  parameter int Width = 2,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bbp_checker.sv]
module bbp_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input bbp_pkg::bbp_out_t        out_o
);

  logic [bbp_pkg::TotalW-1:0] last_total_q;
  logic [1:0]                 pending_q;
  logic                       in_acc;
  logic                       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_total_q <= '0;
      pending_q    <= '0;
    end else begin
      if (out_acc) begin
        last_total_q <= out_o.mispredict_total;
      end
      pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.mispredicted |-> out_o.mispredict_total != '0)
    else $error("mispredict not reflected in total");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.mispredict_total == last_total_q) ||
                    (out_o.mispredict_total == last_total_q + 1'b1))
    else $error("mispredict total jumped");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without transaction");

endmodule

bind bimodal_branch_predictor bbp_checker u_bbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
